[rtl/beq_pkg.sv]
// Types and constants for the button and rotary encoder event queue.
package beq_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int BTN_IDX_W   = 3;
    localparam int LOCKOUT_W   = 16;
    localparam int CODE_W      = 3;
    localparam int COUNT_W     = 5;

    localparam logic [LOCKOUT_W-1:0] BUTTON_LOCKOUT_RESET  = 16'd300;
    localparam logic [LOCKOUT_W-1:0] ENCODER_LOCKOUT_RESET = 16'd40;

    localparam logic REG_BUTTON_LOCKOUT  = 1'b0;
    localparam logic REG_ENCODER_LOCKOUT = 1'b1;

    typedef enum logic [2:0] {
        FN_PLAY      = 3'd0,
        FN_NEXT      = 3'd1,
        FN_PREV      = 3'd2,
        FN_MODE      = 3'd3,
        FN_ENC_PUSH  = 3'd4,
        FN_ENC_EDGE  = 3'd5,
        FN_READ      = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_READ    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [CODE_W-1:0] {
        CODE_PLAY     = 3'd0,
        CODE_NEXT     = 3'd1,
        CODE_PREV     = 3'd2,
        CODE_VOL_UP   = 3'd3,
        CODE_VOL_DOWN = 3'd4,
        CODE_MUTE     = 3'd5,
        CODE_MODE     = 3'd6
    } t_code;

    function automatic t_code button_code(input t_func func);
        t_code code;
        case (func)
            FN_PLAY:     code = CODE_PLAY;
            FN_NEXT:     code = CODE_NEXT;
            FN_PREV:     code = CODE_PREV;
            FN_MODE:     code = CODE_MODE;
            FN_ENC_PUSH: code = CODE_MUTE;
            default:     code = CODE_PLAY;
        endcase
        return code;
    endfunction

endpackage

[rtl/button_encoder_event_queue_unit.sv]
// Top level of the button and rotary encoder event queue with lockout filtering.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_func, i_now, i_clk_level, i_dt_level
//   out     | output    | o_out_valid / i_out_ready| o_status, o_event_code, o_queue_count
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One beat is taken every cycle while o_in_ready is high; its result is registered.
// The lockout compare, queue update and ring write finish in the accepting cycle, and the
// ring read data is registered with the result, then moved to the output register.
// Reset clears the timestamps, pointers and count and needs no clearing pass.
// While the output is stalled, o_in_ready falls once both the pipeline and output registers
// hold a beat.
module button_encoder_event_queue_unit
    import beq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [LOCKOUT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_func,
    input  logic [31:0]          i_now,
    input  logic                 i_clk_level,
    input  logic                 i_dt_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [CODE_W-1:0]    o_event_code,
    output logic [COUNT_W-1:0]   o_queue_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W;

    logic [LOCKOUT_W-1:0] r_btn_lockout;
    logic [LOCKOUT_W-1:0] r_enc_lockout;
    logic [TIME_BITS-1:0] r_btn_time [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_enc_time;
    logic                 r_last_clk;
    logic [CODE_W-1:0]    r_ring [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wp;
    logic [PTR_W-1:0]     r_rp;
    logic [CNT_W-1:0]     r_count;

    logic                 r_p_valid;
    t_status              r_p_status;
    t_code                r_p_code;
    logic [COUNT_W-1:0]   r_p_count;
    logic                 r_p_is_read;
    logic [CODE_W-1:0]    r_rd_data;

    logic                 r_o_valid;
    t_status              r_o_status;
    logic [CODE_W-1:0]    r_o_code;
    logic [COUNT_W-1:0]   r_o_count;

    logic                 accept;
    logic                 p_adv;
    t_func                func;
    logic [63:0]          now64;
    logic [63:0]          btn_lock64;
    logic [63:0]          enc_lock64;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] btn_last;
    logic [TIME_BITS-1:0] btn_diff;
    logic [TIME_BITS-1:0] enc_diff;
    logic                 btn_pass;
    logic                 enc_pass;
    logic                 btn_upd;
    logic                 enc_upd;
    logic                 push_req;
    logic                 do_push;
    logic                 do_pop;
    logic                 q_full;
    logic                 q_empty;
    t_status              n_status;
    t_code                n_code;
    logic [CNT_W-1:0]     n_count;
    logic [15:0]          count16;
    logic [BTN_IDX_W-1:0] btn_idx;

    assign func       = t_func'(i_func);
    assign p_adv      = r_p_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_adv;
    assign accept     = i_in_valid && o_in_ready;

    assign now64      = 64'(i_now);
    assign btn_lock64 = 64'(r_btn_lockout);
    assign enc_lock64 = 64'(r_enc_lockout);
    assign now_t      = now64[TIME_BITS-1:0];
    assign btn_idx    = i_func;

    always_comb begin
        case (btn_idx)
            3'd0:    btn_last = r_btn_time[0];
            3'd1:    btn_last = r_btn_time[1];
            3'd2:    btn_last = r_btn_time[2];
            3'd3:    btn_last = r_btn_time[3];
            3'd4:    btn_last = r_btn_time[4];
            default: btn_last = r_btn_time[0];
        endcase
    end

    assign btn_diff = now_t - btn_last - btn_lock64[TIME_BITS-1:0];
    assign enc_diff = now_t - r_enc_time - enc_lock64[TIME_BITS-1:0];
    assign btn_pass = (btn_diff != '0) && !btn_diff[TIME_BITS-1];
    assign enc_pass = (enc_diff != '0) && !enc_diff[TIME_BITS-1];

    assign q_full  = (r_count == CNT_W'(QUEUE_DEPTH - 1));
    assign q_empty = (r_count == '0);

    always_comb begin
        n_status = ST_IGNORED;
        n_code   = CODE_PLAY;
        btn_upd  = 1'b0;
        enc_upd  = 1'b0;
        push_req = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        case (func)
            FN_PLAY, FN_NEXT, FN_PREV, FN_MODE, FN_ENC_PUSH: begin
                if (btn_pass) begin
                    btn_upd  = 1'b1;
                    n_code   = button_code(func);
                    push_req = 1'b1;
                end
            end
            FN_ENC_EDGE: begin
                if (enc_pass) begin
                    enc_upd = 1'b1;
                    if (r_last_clk && !i_clk_level) begin
                        n_code   = i_dt_level ? CODE_VOL_UP : CODE_VOL_DOWN;
                        push_req = 1'b1;
                    end
                end
            end
            FN_READ: begin
                if (q_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_READ;
                    do_pop   = 1'b1;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
        if (push_req) begin
            if (q_full) begin
                n_status = ST_DROPPED;
            end else begin
                n_status = ST_QUEUED;
                do_push  = 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count16 = 16'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_lockout <= BUTTON_LOCKOUT_RESET;
            r_enc_lockout <= ENCODER_LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUTTON_LOCKOUT:  r_btn_lockout <= i_cfg_data;
                REG_ENCODER_LOCKOUT: r_enc_lockout <= i_cfg_data;
                default:             r_btn_lockout <= r_btn_lockout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_btn_time[i] <= '0;
            end
            r_enc_time <= '0;
            r_last_clk <= 1'b1;
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
        end else if (accept) begin
            if (btn_upd) begin
                r_btn_time[btn_idx] <= now_t;
            end
            if (enc_upd) begin
                r_enc_time <= now_t;
                r_last_clk <= i_clk_level;
            end
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_push) begin
            r_ring[r_wp] <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_ring[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status  <= n_status;
            r_p_code    <= n_code;
            r_p_count   <= count16[COUNT_W-1:0];
            r_p_is_read <= do_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_status <= r_p_status;
            r_o_code   <= r_p_is_read ? r_rd_data : r_p_code;
            r_o_count  <= r_p_count;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_event_code  = r_o_code;
    assign o_queue_count = r_o_count;

endmodule
